@@ rtl/tcps_pkg.sv @@
// Shared types and codes for the two-class preemptive scheduler.
// No dependencies.
`default_nettype none
package tcps_pkg;
   typedef enum logic [2:0] {
      OP_ADD_COMMON = 3'd0,
      OP_ADD_REAL   = 3'd1,
      OP_TERMINATE  = 3'd2,
      OP_SLICE_END  = 3'd3,
      OP_DISK_REQ   = 3'd4,
      OP_DISK_DONE  = 3'd5
   } opcode_type;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_CPU_IDLE  = 3'd1;
   localparam logic [2:0] ST_BAD_DISK  = 3'd2;
   localparam logic [2:0] ST_FULL      = 3'd3;
   localparam logic [2:0] ST_DISK_IDLE = 3'd4;

   localparam logic [2:0] DISKS_RESET = 3'd4;
   localparam int         REG_DISKS   = 0;

   typedef struct packed {
      logic [2:0] opcode;
      logic [1:0] disk_number;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic        cpu_busy;
      logic [15:0] running_pid;
      logic        running_real;
      logic [15:0] new_pid;
   } rsp_type;

   // Controller to datapath: which queue step to take this cycle
   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_LOAD,       // latch item, start reads of all heads
      CMD_PUSH_ADD,   // push new pid to chosen class queue
      CMD_DISPATCH,   // pop next task onto CPU (or go idle)
      CMD_PREEMPT,    // push running to common head, pop realtime
      CMD_ROTATE,     // slice rotation in running class
      CMD_DISK_PUSH,  // push running task to disk queue
      CMD_DISK_POP,   // move disk head to class queue
      CMD_RESPOND     // drive result
   } cmd_type;

   // Datapath to controller: conditions
   typedef struct packed {
      logic busy;
      logic cur_real;
      logic rt_empty;
      logic rt_full;
      logic cm_empty;
      logic cm_full;
      logic disk_ok;
      logic disk_empty;
      logic disk_full;
      logic disk_head_real;
   } flags_type;
endpackage
`default_nettype wire

@@ rtl/tcps_ram.sv @@
// Generic single-write, single-read RAM with registered read.
// No dependencies.
`default_nettype none
module tcps_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write one entry, register the read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

@@ rtl/tcps_datapath.sv @@
// Scheduler datapath: CPU registers, pid counter, ready queues and disk queues.
// Depends on tcps_pkg and tcps_ram.
`default_nettype none
module tcps_datapath
   import tcps_pkg::*;
#(
   parameter int QUEUE_DEPTH      = 16,
   parameter int DISK_COUNT       = 4,
   parameter int DISK_QUEUE_DEPTH = 8,
   parameter int PID_BITS         = 16
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire cmd_type    cmd,
   input  wire req_type    req,
   input  wire logic [2:0] status,
   input  wire logic [2:0] disks_in_use,
   output flags_type       flags,
   output rsp_type         rsp
);
   localparam int QW = $clog2(QUEUE_DEPTH);
   localparam int DW = $clog2(DISK_QUEUE_DEPTH);
   localparam int NW = (DISK_COUNT > 1) ? $clog2(DISK_COUNT) : 1;
   localparam int DA = $clog2(DISK_COUNT * DISK_QUEUE_DEPTH);

   logic                busy_ff, busy_in;
   logic [PID_BITS-1:0] cur_pid_ff, cur_pid_in;
   logic                cur_real_ff, cur_real_in;
   logic [PID_BITS-1:0] pid_ctr_ff, pid_ctr_in;
   logic [PID_BITS-1:0] new_pid_ff, new_pid_in;
   logic [QW-1:0]       rt_head_ff, rt_head_in, cm_head_ff, cm_head_in;
   logic [QW:0]         rt_cnt_ff, rt_cnt_in, cm_cnt_ff, cm_cnt_in;
   logic [DW-1:0]       dk_head_ff [DISK_COUNT];
   logic [DW:0]         dk_cnt_ff  [DISK_COUNT];
   logic [NW-1:0]       dsel_ff;
   logic [1:0]          dnum_ff;
   logic                op_real_ff;

   // Queue RAM ports
   logic                rt_we, cm_we, dk_we;
   logic [QW-1:0]       rt_wa, cm_wa;
   logic [PID_BITS-1:0] rt_wd, cm_wd, rt_rd, cm_rd;
   logic [DA-1:0]       dk_wa, dk_ra;
   logic [PID_BITS:0]   dk_rd;

   logic [QW:0] qdepth;
   logic [DW:0] ddepth;
   logic [PID_BITS-1:0] pid_next;
   logic [DW-1:0] dk_head_sel;
   logic [DW:0]   dk_cnt_sel;
   logic [DW-1:0] dk_tail;

   // Step ready-queue pointers, wrapping at the queue depth
   function automatic logic [QW-1:0] q_next(input logic [QW-1:0] p);
      return (32'(p) == QUEUE_DEPTH - 1) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [QW-1:0] q_prev(input logic [QW-1:0] p);
      return (p == '0) ? QW'(QUEUE_DEPTH - 1) : p - 1'b1;
   endfunction

   function automatic logic [QW-1:0] q_tail(input logic [QW-1:0] h, input logic [QW:0] c);
      logic [QW:0] s;
      s = (QW+1)'(h) + c;
      return (s >= (QW+1)'(QUEUE_DEPTH)) ? QW'(s - (QW+1)'(QUEUE_DEPTH)) : QW'(s);
   endfunction

   // Step disk-queue pointers, wrapping at the disk queue depth
   function automatic logic [DW-1:0] d_next(input logic [DW-1:0] p);
      return (32'(p) == DISK_QUEUE_DEPTH - 1) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [DW-1:0] d_tail(input logic [DW-1:0] h, input logic [DW:0] c);
      logic [DW:0] s;
      s = (DW+1)'(h) + c;
      return (s >= (DW+1)'(DISK_QUEUE_DEPTH)) ? DW'(s - (DW+1)'(DISK_QUEUE_DEPTH)) :
                                                 DW'(s);
   endfunction

   assign qdepth = (QW+1)'(QUEUE_DEPTH);
   assign ddepth = (DW+1)'(DISK_QUEUE_DEPTH);
   assign dk_head_sel = dk_head_ff[dsel_ff];
   assign dk_cnt_sel  = dk_cnt_ff[dsel_ff];
   assign dk_tail = d_tail(dk_head_sel, dk_cnt_sel);
   assign pid_next = (pid_ctr_ff + 1'b1 == '0) ? PID_BITS'(1) : pid_ctr_ff + 1'b1;

   tcps_ram #(.WIDTH(PID_BITS), .DEPTH(QUEUE_DEPTH)) u_rt_ram (
      .clock, .wr_en(rt_we), .wr_addr(rt_wa), .wr_data(rt_wd),
      .rd_addr(rt_head_in), .rd_data(rt_rd));
   tcps_ram #(.WIDTH(PID_BITS), .DEPTH(QUEUE_DEPTH)) u_cm_ram (
      .clock, .wr_en(cm_we), .wr_addr(cm_wa), .wr_data(cm_wd),
      .rd_addr(cm_head_in), .rd_data(cm_rd));
   tcps_ram #(.WIDTH(PID_BITS + 1), .DEPTH(DISK_COUNT * DISK_QUEUE_DEPTH)) u_dk_ram (
      .clock, .wr_en(dk_we), .wr_addr(dk_wa), .wr_data({cur_real_ff, cur_pid_ff}),
      .rd_addr(dk_ra), .rd_data(dk_rd));

   // Disk read address follows the selected disk head; latched item sets selection
   always_comb begin
      logic [NW-1:0] s;
      s = (cmd == CMD_LOAD) ? NW'(req.disk_number) : dsel_ff;
      dk_ra = DA'(s) * DA'(DISK_QUEUE_DEPTH) + DA'(dk_head_ff[s]);
      dk_wa = DA'(dsel_ff) * DA'(DISK_QUEUE_DEPTH) + DA'(dk_tail);
   end

   // Status flags for the controller
   always_comb begin
      flags.busy           = busy_ff;
      flags.cur_real       = cur_real_ff;
      flags.rt_empty       = rt_cnt_ff == '0;
      flags.rt_full        = rt_cnt_ff >= qdepth;
      flags.cm_empty       = cm_cnt_ff == '0;
      flags.cm_full        = cm_cnt_ff >= qdepth;
      flags.disk_ok        = (32'(dnum_ff) < 32'(disks_in_use)) &&
                             (32'(dnum_ff) < DISK_COUNT);
      flags.disk_empty     = dk_cnt_sel == '0;
      flags.disk_full      = dk_cnt_sel >= ddepth;
      flags.disk_head_real = dk_rd[PID_BITS];
   end

   // Next-state datapath for each command
   always_comb begin
      busy_in = busy_ff; cur_pid_in = cur_pid_ff; cur_real_in = cur_real_ff;
      pid_ctr_in = pid_ctr_ff; new_pid_in = new_pid_ff;
      rt_head_in = rt_head_ff; rt_cnt_in = rt_cnt_ff;
      cm_head_in = cm_head_ff; cm_cnt_in = cm_cnt_ff;
      rt_we = 1'b0; cm_we = 1'b0; dk_we = 1'b0;
      rt_wa = q_tail(rt_head_ff, rt_cnt_ff); rt_wd = cur_pid_ff;
      cm_wa = q_tail(cm_head_ff, cm_cnt_ff); cm_wd = cur_pid_ff;
      case (cmd)
         CMD_LOAD: begin
            new_pid_in = '0;
         end
         CMD_PUSH_ADD: begin
            new_pid_in = pid_ctr_ff;
            pid_ctr_in = pid_next;
            if (op_real_ff) begin
               rt_we = 1'b1; rt_wd = pid_ctr_ff; rt_cnt_in = rt_cnt_ff + 1'b1;
            end else begin
               cm_we = 1'b1; cm_wd = pid_ctr_ff; cm_cnt_in = cm_cnt_ff + 1'b1;
            end
         end
         CMD_DISPATCH: begin
            if (rt_cnt_ff != '0) begin
               busy_in = 1'b1; cur_pid_in = rt_rd; cur_real_in = 1'b1;
               rt_head_in = q_next(rt_head_ff); rt_cnt_in = rt_cnt_ff - 1'b1;
            end else if (cm_cnt_ff != '0) begin
               busy_in = 1'b1; cur_pid_in = cm_rd; cur_real_in = 1'b0;
               cm_head_in = q_next(cm_head_ff); cm_cnt_in = cm_cnt_ff - 1'b1;
            end else begin
               busy_in = 1'b0; cur_pid_in = '0; cur_real_in = 1'b0;
            end
         end
         CMD_PREEMPT: begin
            cm_head_in = q_prev(cm_head_ff); cm_we = 1'b1; cm_wa = q_prev(cm_head_ff);
            cm_cnt_in = cm_cnt_ff + 1'b1;
            cur_pid_in = rt_rd; cur_real_in = 1'b1;
            rt_head_in = q_next(rt_head_ff); rt_cnt_in = rt_cnt_ff - 1'b1;
         end
         CMD_ROTATE: begin
            // pop head, push running at tail; count unchanged
            if (cur_real_ff) begin
               cur_pid_in = rt_rd; rt_we = 1'b1; rt_head_in = q_next(rt_head_ff);
            end else begin
               cur_pid_in = cm_rd; cm_we = 1'b1; cm_head_in = q_next(cm_head_ff);
            end
         end
         CMD_DISK_PUSH: begin
            dk_we = 1'b1;
         end
         CMD_DISK_POP: begin
            if (dk_rd[PID_BITS]) begin
               rt_we = 1'b1; rt_wd = dk_rd[PID_BITS-1:0]; rt_cnt_in = rt_cnt_ff + 1'b1;
            end else begin
               cm_we = 1'b1; cm_wd = dk_rd[PID_BITS-1:0]; cm_cnt_in = cm_cnt_ff + 1'b1;
            end
         end
         default: ;
      endcase
   end

   // Hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; cur_pid_ff <= '0; cur_real_ff <= 1'b0;
         pid_ctr_ff <= PID_BITS'(1); new_pid_ff <= '0;
         rt_head_ff <= '0; rt_cnt_ff <= '0; cm_head_ff <= '0; cm_cnt_ff <= '0;
         dsel_ff <= '0; dnum_ff <= '0; op_real_ff <= 1'b0;
         for (int i = 0; i < DISK_COUNT; i++) begin
            dk_head_ff[i] <= '0; dk_cnt_ff[i] <= '0;
         end
      end else begin
         busy_ff <= busy_in; cur_pid_ff <= cur_pid_in; cur_real_ff <= cur_real_in;
         pid_ctr_ff <= pid_ctr_in; new_pid_ff <= new_pid_in;
         rt_head_ff <= rt_head_in; rt_cnt_ff <= rt_cnt_in;
         cm_head_ff <= cm_head_in; cm_cnt_ff <= cm_cnt_in;
         if (cmd == CMD_LOAD) begin
            dsel_ff <= NW'(req.disk_number);
            dnum_ff <= req.disk_number;
            op_real_ff <= req.opcode == OP_ADD_REAL;
         end
         if (cmd == CMD_DISK_PUSH) begin
            dk_cnt_ff[dsel_ff] <= dk_cnt_sel + 1'b1;
         end
         if (cmd == CMD_DISK_POP) begin
            dk_cnt_ff[dsel_ff]  <= dk_cnt_sel - 1'b1;
            dk_head_ff[dsel_ff] <= d_next(dk_head_sel);
         end
      end
   end

   // Result fields
   always_comb begin
      rsp.status       = status;
      rsp.cpu_busy     = busy_ff;
      rsp.running_pid  = busy_ff ? 16'(cur_pid_ff) : 16'd0;
      rsp.running_real = busy_ff & cur_real_ff;
      rsp.new_pid      = 16'(new_pid_ff);
   end
endmodule
`default_nettype wire

@@ rtl/tcps_ctrl.sv @@
// Scheduler controller: sequences queue steps for each event.
// Depends on tcps_pkg.
`default_nettype none
module tcps_ctrl
   import tcps_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   input  wire req_type    req,
   input  wire flags_type  flags,
   output cmd_type         cmd,
   output logic [2:0]      status,
   output logic            busy,
   output logic            done
);
   typedef enum logic [2:0] {
      S_IDLE, S_DECODE, S_WAIT, S_CLAIM, S_DISPATCH, S_RESPOND
   } state_type;

   state_type  state_ff;
   logic [2:0] op_ff;
   logic [2:0] status_ff;

   assign busy   = state_ff != S_IDLE;
   assign status = status_ff;
   assign done   = state_ff == S_RESPOND;

   // Command for the current state (a pushed queue entry reaches the head only
   // through the registered RAM read, hence the wait before the CPU claim)
   always_comb begin
      cmd = CMD_NONE;
      case (state_ff)
         S_IDLE: if (start) cmd = CMD_LOAD;
         S_DECODE: begin
            case (op_ff)
               OP_ADD_COMMON: if (!flags.cm_full) cmd = CMD_PUSH_ADD;
               OP_ADD_REAL:   if (!flags.rt_full) cmd = CMD_PUSH_ADD;
               OP_TERMINATE:  if (flags.busy) cmd = CMD_DISPATCH;
               OP_SLICE_END: begin
                  if (flags.busy && ((flags.cur_real && !flags.rt_empty) ||
                                     (!flags.cur_real && !flags.cm_empty)))
                     cmd = CMD_ROTATE;
               end
               OP_DISK_REQ: begin
                  if (flags.disk_ok && flags.busy && !flags.disk_full) cmd = CMD_DISK_PUSH;
               end
               OP_DISK_DONE: begin
                  if (flags.disk_ok && !flags.disk_empty &&
                      !(flags.disk_head_real ? flags.rt_full : flags.cm_full))
                     cmd = CMD_DISK_POP;
               end
               default: ;
            endcase
         end
         S_CLAIM: begin
            if (!flags.busy) cmd = CMD_DISPATCH;
            else if (!flags.cur_real && !flags.rt_empty && !flags.cm_full) cmd = CMD_PREEMPT;
         end
         S_DISPATCH: cmd = CMD_DISPATCH;
         default: ;
      endcase
   end

   // Hold state and status
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; op_ff <= '0; status_ff <= ST_OK;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  op_ff <= req.opcode; status_ff <= ST_OK; state_ff <= S_DECODE;
               end
            end
            S_DECODE: begin
               state_ff <= S_RESPOND;
               case (op_ff)
                  OP_ADD_COMMON, OP_ADD_REAL: begin
                     if (cmd == CMD_PUSH_ADD) state_ff <= S_WAIT;
                     else status_ff <= ST_FULL;
                  end
                  OP_TERMINATE, OP_SLICE_END: if (!flags.busy) status_ff <= ST_CPU_IDLE;
                  OP_DISK_REQ: begin
                     if (!flags.disk_ok) status_ff <= ST_BAD_DISK;
                     else if (!flags.busy) status_ff <= ST_CPU_IDLE;
                     else if (flags.disk_full) status_ff <= ST_FULL;
                     else state_ff <= S_DISPATCH;
                  end
                  OP_DISK_DONE: begin
                     if (!flags.disk_ok) status_ff <= ST_BAD_DISK;
                     else if (flags.disk_empty) status_ff <= ST_DISK_IDLE;
                     else if (cmd != CMD_DISK_POP) status_ff <= ST_FULL;
                     else state_ff <= S_WAIT;
                  end
                  default: ;
               endcase
            end
            S_WAIT:     state_ff <= S_CLAIM;
            S_CLAIM:    state_ff <= S_RESPOND;
            S_DISPATCH: state_ff <= S_RESPOND;
            S_RESPOND:  state_ff <= S_IDLE;
            default:    state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

@@ rtl/two_class_preemptive_scheduler_core.sv @@
// Top level of the two-class preemptive scheduler.
// Depends on tcps_pkg, tcps_ctrl, tcps_datapath and tcps_ram.
//
// Usage: drive req_payload and pulse start while busy is low; the item is
// taken at that edge. One result per item appears on rsp_payload for one
// cycle with rsp_valid high; the receiver cannot hold it off.
// Flow after the accept edge: events that fail or need one queue step
// (terminate, slice end) go from decode straight to the result; a disk
// request (push then dispatch) passes a dispatch state; adds and disk done
// pass a wait state (queue push, pushed entry reaching the registered head
// read) and a claim state. No item is accepted before the last result;
// busy stays high from the accept edge through the result cycle, then drops.
// Register disks_in_use sits at CSR address 0 (reset 4); write only while
// idle. Reset clears the CPU, counters and queue pointers; queue RAMs need
// no clearing since only entries below each count are read.
`default_nettype none
module two_class_preemptive_scheduler_core
   import tcps_pkg::*;
#(
   parameter int QUEUE_DEPTH      = 16,
   parameter int DISK_COUNT       = 4,
   parameter int DISK_QUEUE_DEPTH = 8,
   parameter int PID_BITS         = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire req_type     req_payload,
   output logic             rsp_valid,
   output rsp_type          rsp_payload,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [1:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);
   cmd_type    cmd;
   flags_type  flags;
   logic [2:0] status;
   logic [2:0] disks_ff;
   rsp_type    rsp;

   // Config register
   assign pready = 1'b1;
   assign prdata = (paddr[1:0] == 2'(REG_DISKS * 4)) ? {29'd0, disks_ff} : 32'd0;
   always_ff @(posedge clock) begin
      if (reset) begin
         disks_ff <= DISKS_RESET;
      end else if (psel && penable && pwrite && paddr == 2'(REG_DISKS * 4)) begin
         disks_ff <= pwdata[2:0];
      end
   end

   tcps_ctrl u_ctrl (
      .clock, .reset, .start, .req(req_payload), .flags, .cmd,
      .status, .busy, .done(rsp_valid));

   tcps_datapath #(
      .QUEUE_DEPTH(QUEUE_DEPTH), .DISK_COUNT(DISK_COUNT),
      .DISK_QUEUE_DEPTH(DISK_QUEUE_DEPTH), .PID_BITS(PID_BITS)
   ) u_dp (
      .clock, .reset, .cmd, .req(req_payload), .status,
      .disks_in_use(disks_ff), .flags, .rsp);

   assign rsp_payload = rsp;

`ifndef SYNTHESIS
   a_idle_pid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.cpu_busy |-> rsp_payload.running_pid == 16'd0)
      else $error("idle cpu reports a pid");
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted item did not raise busy");
   a_one_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");
`endif
endmodule
`default_nettype wire
